// ===== design/xmlp_pkg.sv =====
// shared types and constants for the module length parser
package xmlp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_HEADER   = 3'd1,
        PH_PAT      = 3'd2,
        PH_INS      = 3'd3,
        PH_SMP      = 3'd4,
        PH_HOLD_OK  = 3'd5,
        PH_HOLD_BAD = 3'd6
    } phase_t;

    localparam logic [2:0] ST_COMPLETE  = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_SIGNATURE = 3'd2;
    localparam logic [2:0] ST_COUNTS    = 3'd3;
    localparam logic [2:0] ST_TRUNCATED = 3'd4;
    localparam logic [2:0] ST_MALFORMED = 3'd5;

    localparam logic [1:0] REG_PATTERN_LIMIT    = 2'd0;
    localparam logic [1:0] REG_INSTRUMENT_LIMIT = 2'd1;
    localparam logic [1:0] REG_MINIMUM_LENGTH   = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_flag;
        logic       end_flag;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] module_length;
    } result_t;

    typedef struct packed {
        logic [15:0] pattern_limit;
        logic [15:0] instrument_limit;
        logic [15:0] minimum_length;
    } cfg_t;

endpackage

// ===== design/xmlp_front.sv =====
// input side: accepts stream words and keeps a short queue of items
module xmlp_front
    import xmlp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [1:0]  s_tuser,
    output logic        q_valid,
    input  logic        q_pop,
    output item_t       q_item
);

    item_t      mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    item_t      in_item;

    assign s_tready  = (count_reg != 2'(QUEUE_DEPTH));
    assign push      = s_tvalid && s_tready;
    assign q_valid   = (count_reg != 2'd0);
    assign q_item    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        in_item.data_byte  = s_tdata;
        in_item.start_flag = s_tuser[0];
        in_item.end_flag   = s_tuser[1];
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule

// ===== design/xmlp_back.sv =====
// walking parser: one queued byte per cycle while the output is not stalled, result into an output register
module xmlp_back
    import xmlp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_valid,
    output logic        q_pop,
    input  item_t       q_item,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata
);

    phase_t      phase_reg, phase_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] ptr_reg, ptr_next;
    logic [31:0] gather_reg, gather_next;
    logic [15:0] pat_reg, pat_next;
    logic [15:0] ins_reg, ins_next;
    logic [15:0] smp_reg, smp_next;
    logic [15:0] ihs_reg, ihs_next;
    logic [31:0] sum_reg, sum_next;
    logic        ovalid_reg, ovalid_next;
    result_t     res_reg, res_next;

    logic        take;
    logic [7:0]  b;
    logic [31:0] o, rel;
    logic [32:0] count;
    logic        ready;
    logic        emit;
    result_t     emit_val;
    logic [32:0] adv_nb;
    logic        adv_en;
    logic [32:0] sum33;
    logic [32:0] nb40;
    logic [15:0] pat_dec, ins_dec;
    logic [15:0] pat_w, ins_w;
    logic [32:0] ins_nb;

    // queue pops when the output register is free or being drained
    assign take  = q_valid && (!ovalid_reg || m_tready);
    assign q_pop = take;
    assign b     = q_item.data_byte;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {5'd0, res_reg.module_length, res_reg.status};

    // record advance shared by header, pattern, instrument and sample paths
    always_comb
    begin
        phase_next  = phase_reg;
        offset_next = offset_reg;
        ptr_next    = ptr_reg;
        gather_next = gather_reg;
        pat_next    = pat_reg;
        ins_next    = ins_reg;
        smp_next    = smp_reg;
        ihs_next    = ihs_reg;
        sum_next    = sum_reg;
        ovalid_next = ovalid_reg && !m_tready;
        res_next    = res_reg;
        emit        = 1'b0;
        emit_val    = '0;
        adv_en      = 1'b0;
        adv_nb      = '0;
        o           = '0;
        rel         = '0;
        count       = '0;
        ready       = 1'b0;
        sum33       = '0;
        nb40        = '0;
        ins_nb      = '0;
        pat_w       = pat_reg;
        ins_w       = ins_reg;
        pat_dec     = pat_reg - 16'd1;
        ins_dec     = ins_reg - 16'd1;

        if (take)
        begin
            if (q_item.start_flag)
            begin
                phase_next  = PH_HEADER;
                offset_next = '0;
                ptr_next    = '0;
                gather_next = '0;
                pat_next    = '0;
                ins_next    = '0;
                smp_next    = '0;
                ihs_next    = '0;
                sum_next    = '0;
                o           = '0;
            end
            else
                o = offset_reg;

            if (q_item.start_flag || phase_reg != PH_IDLE)
            begin
                count       = {1'b0, o} + 33'd1;
                offset_next = count[31:0];
                rel         = o - ptr_next;
                pat_w       = pat_next;
                ins_w       = ins_next;
                pat_dec     = pat_next - 16'd1;
                ins_dec     = ins_next - 16'd1;

                case (phase_next)
                    PH_HEADER:
                    begin
                        if ((o == 32'd37 && b != 8'h1A) || (o == 32'd58 && b != 8'h04))
                            ptr_next = 32'(ST_SIGNATURE);
                        if (o >= 32'd60 && o <= 32'd63)
                            gather_next = gather_next | (32'(b) << {o[1:0], 3'b000});
                        if (o == 32'd70) pat_next = {8'd0, b};
                        if (o == 32'd71) pat_next = {b, pat_next[7:0]};
                        if (o == 32'd72) ins_next = {8'd0, b};
                        if (o == 32'd73)
                        begin
                            ins_next = {b, ins_next[7:0]};
                            pat_w    = pat_next;
                            ins_w    = ins_next;
                            if (ptr_next == 32'(ST_SIGNATURE))
                                phase_next = PH_HOLD_BAD;
                            else if (pat_next > cfg.pattern_limit ||
                                     ins_next > cfg.instrument_limit)
                            begin
                                phase_next = PH_HOLD_BAD;
                                ptr_next   = 32'(ST_COUNTS);
                            end
                            else
                            begin
                                adv_en = 1'b1;
                                adv_nb = {1'b0, gather_next} + 33'd60;
                            end
                        end
                    end
                    PH_PAT:
                    begin
                        if (o >= ptr_next)
                        begin
                            if (rel == 32'd7) gather_next = {24'd0, b};
                            if (rel == 32'd8)
                            begin
                                pat_next = pat_dec;
                                pat_w    = pat_dec;
                                adv_en   = 1'b1;
                                adv_nb   = {1'b0, ptr_next} + 33'd9 +
                                           {17'd0, b, gather_next[7:0]};
                            end
                        end
                    end
                    PH_INS:
                    begin
                        if (o >= ptr_next)
                        begin
                            if (rel == 32'd0) ihs_next = {8'd0, b};
                            if (rel == 32'd1) ihs_next = {b, ihs_next[7:0]};
                            if (rel == 32'd27) smp_next = {8'd0, b};
                            if (rel == 32'd28)
                            begin
                                smp_next = {b, smp_next[7:0]};
                                sum_next = '0;
                                ins_nb   = {1'b0, ptr_next} + {17'd0, ihs_next};
                                if (smp_next != 16'd0)
                                begin
                                    if (ins_nb <= {1'b0, o} ||
                                        ins_nb + 33'd3 > 33'hFFFFFFFF)
                                    begin
                                        phase_next = PH_HOLD_BAD;
                                        ptr_next   = 32'(ST_MALFORMED);
                                    end
                                    else
                                    begin
                                        phase_next = PH_SMP;
                                        ptr_next   = ins_nb[31:0];
                                    end
                                end
                                else
                                begin
                                    ins_next = ins_dec;
                                    ins_w    = ins_dec;
                                    adv_en   = 1'b1;
                                    adv_nb   = ins_nb;
                                end
                            end
                        end
                    end
                    PH_SMP:
                    begin
                        if (o >= ptr_next)
                        begin
                            if (rel == 32'd0) gather_next = {24'd0, b};
                            if (rel >= 32'd1 && rel <= 32'd3)
                                gather_next = gather_next | (32'(b) << {rel[1:0], 3'b000});
                            if (rel == 32'd3)
                            begin
                                sum33 = {1'b0, sum_next} + {1'b0, gather_next};
                                nb40  = {1'b0, ptr_next} + 33'd40;
                                if (sum33[32])
                                begin
                                    phase_next = PH_HOLD_BAD;
                                    ptr_next   = 32'(ST_MALFORMED);
                                end
                                else
                                begin
                                    sum_next = sum33[31:0];
                                    smp_next = smp_reg - 16'd1;
                                    if (smp_next != 16'd0)
                                    begin
                                        if (nb40 + 33'd3 > 33'hFFFFFFFF)
                                        begin
                                            phase_next = PH_HOLD_BAD;
                                            ptr_next   = 32'(ST_MALFORMED);
                                        end
                                        else
                                            ptr_next = nb40[31:0];
                                    end
                                    else
                                    begin
                                        ins_next = ins_dec;
                                        ins_w    = ins_dec;
                                        adv_en   = 1'b1;
                                        adv_nb   = nb40 + sum33;
                                    end
                                end
                            end
                        end
                    end
                    default: ;
                endcase

                if (adv_en)
                begin
                    if (pat_w != 16'd0)
                    begin
                        if (adv_nb + 33'd8 > 33'hFFFFFFFF || adv_nb + 33'd7 <= {1'b0, o})
                        begin
                            phase_next = PH_HOLD_BAD;
                            ptr_next   = 32'(ST_MALFORMED);
                        end
                        else
                        begin
                            phase_next = PH_PAT;
                            ptr_next   = adv_nb[31:0];
                        end
                    end
                    else if (ins_w != 16'd0)
                    begin
                        if (adv_nb + 33'd28 > 33'hFFFFFFFF || adv_nb <= {1'b0, o})
                        begin
                            phase_next = PH_HOLD_BAD;
                            ptr_next   = 32'(ST_MALFORMED);
                        end
                        else
                        begin
                            phase_next = PH_INS;
                            ptr_next   = adv_nb[31:0];
                        end
                    end
                    else if (adv_nb[32])
                    begin
                        phase_next = PH_HOLD_BAD;
                        ptr_next   = 32'(ST_MALFORMED);
                    end
                    else
                    begin
                        phase_next = PH_HOLD_OK;
                        ptr_next   = adv_nb[31:0];
                    end
                end

                ready = count >= {17'd0, cfg.minimum_length};
                if (phase_next == PH_HOLD_OK || phase_next == PH_HOLD_BAD)
                begin
                    if (ready)
                    begin
                        emit = 1'b1;
                        if (phase_next == PH_HOLD_OK)
                            emit_val = '{status: ST_COMPLETE, module_length: ptr_next};
                        else
                            emit_val = '{status: ptr_next[2:0], module_length: count[31:0]};
                    end
                    else if (q_item.end_flag)
                    begin
                        emit     = 1'b1;
                        emit_val = '{status: ST_SHORT, module_length: count[31:0]};
                    end
                end
                else if (q_item.end_flag)
                begin
                    emit     = 1'b1;
                    emit_val = '{status: (ready ? ST_TRUNCATED : ST_SHORT),
                                 module_length: count[31:0]};
                end

                if (emit)
                begin
                    phase_next  = PH_IDLE;
                    ovalid_next = 1'b1;
                    res_next    = emit_val;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            offset_reg <= '0;
            ptr_reg    <= '0;
            gather_reg <= '0;
            pat_reg    <= '0;
            ins_reg    <= '0;
            smp_reg    <= '0;
            ihs_reg    <= '0;
            sum_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            ptr_reg    <= ptr_next;
            gather_reg <= gather_next;
            pat_reg    <= pat_next;
            ins_reg    <= ins_next;
            smp_reg    <= smp_next;
            ihs_reg    <= ihs_next;
            sum_reg    <= sum_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

// ===== design/xmlp_regs.sv =====
// apb register file for the limits
module xmlp_regs
    import xmlp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg, cfg_next;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            case (idx)
                REG_PATTERN_LIMIT:    cfg_next.pattern_limit    = pwdata[15:0];
                REG_INSTRUMENT_LIMIT: cfg_next.instrument_limit = pwdata[15:0];
                REG_MINIMUM_LENGTH:   cfg_next.minimum_length   = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_PATTERN_LIMIT:    prdata = {16'd0, cfg_reg.pattern_limit};
            REG_INSTRUMENT_LIMIT: prdata = {16'd0, cfg_reg.instrument_limit};
            REG_MINIMUM_LENGTH:   prdata = {16'd0, cfg_reg.minimum_length};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_limit    <= 16'd256;
            cfg_reg.instrument_limit <= 16'd128;
            cfg_reg.minimum_length   <= 16'd336;
        end
        else
            cfg_reg <= cfg_next;
    end

endmodule

// ===== design/xm_module_length_parser_top.sv =====
// top level of the tracker module length parser
// input stream: one byte per word, tuser carries start and end marks;
//   a start mark restarts parsing at offset zero, bytes outside a candidate
//   are dropped
// output stream: at most one word per candidate with status and module length
// throughput: one input word per cycle while the output is not stalled; the walker
//   handles one byte per cycle, limited by its single offset and pointer update
// path: a word is registered in a two-entry queue before it is parsed; a
//   verdict appears on the output in the cycle after its deciding byte
//   is parsed
// stall: a result held in the output register while m_tready is low stops the
//   walker, the queue fills up to its two entries, then s_tready drops
// reset: queue and output are emptied, the parser goes idle, limits return
//   to 256 patterns, 128 instruments and 336 bytes minimum length
// the apb port writes limits; write them only while no candidate is open
module xm_module_length_parser_top
    import xmlp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic [1:0]  s_tuser,   // start_flag, end_flag
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[2:0], module_length[34:3]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t  cfg;
    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    xmlp_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    xmlp_front u_front (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .q_valid(q_valid), .q_pop(q_pop),
        .q_item(q_item)
    );

    xmlp_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .q_valid(q_valid), .q_pop(q_pop),
        .q_item(q_item), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

endmodule

// ===== design/xmlp_checker.sv =====
// port checker for the parser, bound to the top level
module xmlp_checker
    import xmlp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= ST_MALFORMED && m_tdata[39:35] == 5'd0)
        else $error("bad status or padding");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    // with output free, the queue drains so input cannot stay blocked
    a_no_lock: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready && !m_tvalid |=> s_tready)
        else $error("input blocked with no result pending");

endmodule

bind xm_module_length_parser_top xmlp_checker u_xmlp_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .pready(pready)
);
